### hdl/clcd_pkg.sv
// Shared types and constants for the character LCD nibble interface.
// No dependencies; every other file in hdl/ uses this package by scoped names.
package clcd_pkg;

  // Width of the phase tick counter; loaded counts saturate at its maximum.
  localparam int TICK_COUNT_WIDTH = 18;
  // Widest timing register (power-up wait).
  localparam int CFG_COUNT_W = 18;
  localparam int CMP_W = (TICK_COUNT_WIDTH > CFG_COUNT_W) ? TICK_COUNT_WIDTH : CFG_COUNT_W;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 18;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_HIGH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_LOW   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_GAP  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_WAIT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_WAIT   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WAKE_WAIT    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_FLAGS = 3'd6;

  // Action codes of an input item.
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_INIT = 2'd1;
  localparam logic [1:0] ACT_PUT  = 2'd2;

  // Control characters recognized by a put.
  localparam logic [7:0] CH_LINE_FEED = 8'd10;
  localparam logic [7:0] CH_FORM_FEED = 8'd12;
  localparam logic [7:0] CH_CARRIAGE_RETURN = 8'd13;

  // Controller commands and nibbles.
  localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
  localparam logic [7:0] CMD_LINE_TWO    = 8'h40;
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_FOUR_BIT    = 8'h32;
  localparam logic [7:0] CMD_FUNCTION    = 8'h28;
  localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] CMD_DISPLAY     = 8'h08;
  localparam logic [3:0] NIB_WAKE        = 4'h3;
  localparam logic [2:0] DISPLAY_FLAG_MASK = 3'h7;

  // Init sequence steps.
  localparam logic [3:0] STEP_POWER      = 4'd0;
  localparam logic [3:0] STEP_WAKE_ONE   = 4'd1;
  localparam logic [3:0] STEP_WAKE_TWO   = 4'd2;
  localparam logic [3:0] STEP_FOUR_BIT   = 4'd3;
  localparam logic [3:0] STEP_FUNCTION   = 4'd4;
  localparam logic [3:0] STEP_DISP_OFF   = 4'd5;
  localparam logic [3:0] STEP_CLEAR      = 4'd6;
  localparam logic [3:0] STEP_ENTRY      = 4'd7;
  localparam logic [3:0] STEP_DISP_ON    = 4'd8;
  localparam logic [3:0] STEP_DONE       = 4'd9;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_EHIGH = 5'b00010,
    PH_ELOW  = 5'b00100,
    PH_GAP   = 5'b01000,
    PH_POST  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0]  enable_high_ticks;
    logic [9:0]  enable_low_ticks;
    logic [9:0]  command_gap_ticks;
    logic [15:0] clear_wait_ticks;
    logic [17:0] power_wait_ticks;
    logic [15:0] wake_wait_ticks;
    logic [2:0]  display_on_flags;
  } cfg_t;

  typedef struct packed {
    logic       reg_select;
    logic       enable_pin;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic       dropped;
  } result_t;

  // Sequencer to top: hold off input while phases chain, result ready this cycle.
  typedef struct packed {
    logic    hold;
    logic    done;
    result_t result;
  } seq_status_t;

endpackage

### hdl/clcd_cfg_regs.sv
// Configuration register file of the character LCD nibble interface.
// Depends on clcd_pkg for the register indexes and the cfg_t bundle.
module clcd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [clcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output clcd_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_high_ticks <= 8'd3;
      cfg.enable_low_ticks  <= 10'd100;
      cfg.command_gap_ticks <= 10'd100;
      cfg.clear_wait_ticks  <= 16'd5000;
      cfg.power_wait_ticks  <= 18'd100000;
      cfg.wake_wait_ticks   <= 16'd5000;
      cfg.display_on_flags  <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        clcd_pkg::REG_ENABLE_HIGH:   cfg.enable_high_ticks <= cfg_wdata[7:0];
        clcd_pkg::REG_ENABLE_LOW:    cfg.enable_low_ticks  <= cfg_wdata[9:0];
        clcd_pkg::REG_COMMAND_GAP:   cfg.command_gap_ticks <= cfg_wdata[9:0];
        clcd_pkg::REG_CLEAR_WAIT:    cfg.clear_wait_ticks  <= cfg_wdata[15:0];
        clcd_pkg::REG_POWER_WAIT:    cfg.power_wait_ticks  <= cfg_wdata[17:0];
        clcd_pkg::REG_WAKE_WAIT:     cfg.wake_wait_ticks   <= cfg_wdata[15:0];
        clcd_pkg::REG_DISPLAY_FLAGS: cfg.display_on_flags  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/clcd_sequencer.sv
// Phase sequencer of the character LCD nibble interface: state registers, the
// per-item update and at most one phase change per cycle. Depends on clcd_pkg.
module clcd_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  clcd_pkg::cfg_t      cfg,
  input  logic                item_accept,
  input  logic [1:0]          action,
  input  logic [7:0]          char_code,
  output clcd_pkg::seq_status_t status
);

  localparam int TW = clcd_pkg::TICK_COUNT_WIDTH;
  localparam int CW = clcd_pkg::CFG_COUNT_W;
  localparam int MW = clcd_pkg::CMP_W;

  typedef struct packed {
    clcd_pkg::phase_t phase;
    logic [TW-1:0]    tick_count;
    logic [3:0]       init_step;
    logic [7:0]       pending_byte;
    logic             low_half_next;
    logic             is_command;
    logic [TW-1:0]    after_wait;
    logic             pin_rs;
    logic             pin_e;
    logic [3:0]       pin_data;
  } seq_state_t;

  seq_state_t state, state_next, state_act, state_base;
  logic       drop_now;

  function automatic logic [TW-1:0] sat_count(input logic [CW-1:0] v);
    logic [MW-1:0] ext;
    logic [MW-1:0] top;
    ext = MW'(v);
    top = MW'({TW{1'b1}});
    if (ext > top) return {TW{1'b1}};
    return TW'(ext);
  endfunction

  function automatic seq_state_t drive_nibble(input seq_state_t s, input logic [3:0] nib,
                                              input clcd_pkg::cfg_t c);
    seq_state_t r;
    r = s;
    r.pin_data   = nib;
    r.pin_e      = 1'b1;
    r.phase      = clcd_pkg::PH_EHIGH;
    r.tick_count = sat_count(CW'(c.enable_high_ticks));
    return r;
  endfunction

  function automatic seq_state_t send_byte(input seq_state_t s, input logic [7:0] b,
                                           input logic rs, input logic cmd,
                                           input logic [CW-1:0] wait_ticks,
                                           input clcd_pkg::cfg_t c);
    seq_state_t r;
    r = s;
    r.pending_byte  = b;
    r.pin_rs        = rs;
    r.is_command    = cmd;
    r.after_wait    = sat_count(wait_ticks);
    r.low_half_next = 1'b1;
    return drive_nibble(r, b[7:4], c);
  endfunction

  function automatic seq_state_t send_single(input seq_state_t s, input logic [3:0] nib,
                                             input logic [CW-1:0] wait_ticks,
                                             input clcd_pkg::cfg_t c);
    seq_state_t r;
    r = s;
    r.pending_byte  = {4'h0, nib};
    r.pin_rs        = 1'b0;
    r.is_command    = 1'b0;
    r.after_wait    = sat_count(wait_ticks);
    r.low_half_next = 1'b0;
    return drive_nibble(r, nib, c);
  endfunction

  function automatic seq_state_t begin_item(input seq_state_t s, input logic [3:0] k,
                                            input clcd_pkg::cfg_t c);
    seq_state_t r;
    r = s;
    r.init_step = k + 4'd1;
    case (k)
      clcd_pkg::STEP_POWER: begin
        r.phase      = clcd_pkg::PH_POST;
        r.tick_count = sat_count(c.power_wait_ticks);
      end
      clcd_pkg::STEP_WAKE_ONE:
        r = send_single(r, clcd_pkg::NIB_WAKE, CW'(c.wake_wait_ticks), c);
      clcd_pkg::STEP_WAKE_TWO:
        r = send_single(r, clcd_pkg::NIB_WAKE, '0, c);
      clcd_pkg::STEP_FOUR_BIT:
        r = send_byte(r, clcd_pkg::CMD_FOUR_BIT, 1'b0, 1'b1, '0, c);
      clcd_pkg::STEP_FUNCTION:
        r = send_byte(r, clcd_pkg::CMD_FUNCTION, 1'b0, 1'b1, '0, c);
      clcd_pkg::STEP_DISP_OFF:
        r = send_byte(r, clcd_pkg::CMD_DISPLAY, 1'b0, 1'b1, '0, c);
      clcd_pkg::STEP_CLEAR:
        r = send_byte(r, clcd_pkg::CMD_CLEAR, 1'b0, 1'b1, CW'(c.clear_wait_ticks), c);
      clcd_pkg::STEP_ENTRY:
        r = send_byte(r, clcd_pkg::CMD_ENTRY_MODE, 1'b0, 1'b1, '0, c);
      clcd_pkg::STEP_DISP_ON:
        r = send_byte(r, clcd_pkg::CMD_DISPLAY |
                      {5'd0, c.display_on_flags & clcd_pkg::DISPLAY_FLAG_MASK},
                      1'b0, 1'b1, '0, c);
      default: begin
        r.phase      = clcd_pkg::PH_IDLE;
        r.tick_count = '0;
        r.init_step  = clcd_pkg::STEP_DONE;
      end
    endcase
    return r;
  endfunction

  // One phase change once the current phase has run out.
  function automatic seq_state_t settle_step(input seq_state_t s, input clcd_pkg::cfg_t c);
    seq_state_t r;
    r = s;
    case (s.phase)
      clcd_pkg::PH_EHIGH: begin
        r.pin_e      = 1'b0;
        r.phase      = clcd_pkg::PH_ELOW;
        r.tick_count = sat_count(CW'(c.enable_low_ticks));
      end
      clcd_pkg::PH_ELOW: begin
        if (s.low_half_next) begin
          r.low_half_next = 1'b0;
          r = drive_nibble(r, s.pending_byte[3:0], c);
        end else if (s.is_command) begin
          r.phase      = clcd_pkg::PH_GAP;
          r.tick_count = sat_count(CW'(c.command_gap_ticks));
        end else begin
          r.phase      = clcd_pkg::PH_POST;
          r.tick_count = s.after_wait;
        end
      end
      clcd_pkg::PH_GAP: begin
        r.phase      = clcd_pkg::PH_POST;
        r.tick_count = s.after_wait;
      end
      clcd_pkg::PH_POST: r = begin_item(s, s.init_step, c);
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic needs_settle(input seq_state_t s);
    return (s.phase != clcd_pkg::PH_IDLE) && (s.tick_count == '0);
  endfunction

  // Apply the accepted item to the current state.
  always_comb begin
    state_act = state;
    drop_now  = 1'b0;
    case (action)
      clcd_pkg::ACT_TICK: begin
        if (state.phase != clcd_pkg::PH_IDLE && state.tick_count != '0) begin
          state_act.tick_count = state.tick_count - TW'(1);
        end
      end
      clcd_pkg::ACT_INIT: begin
        if (state.phase != clcd_pkg::PH_IDLE) begin
          drop_now = 1'b1;
        end else begin
          state_act = begin_item(state, clcd_pkg::STEP_POWER, cfg);
        end
      end
      clcd_pkg::ACT_PUT: begin
        if (state.phase != clcd_pkg::PH_IDLE) begin
          drop_now = 1'b1;
        end else begin
          if (char_code == clcd_pkg::CH_CARRIAGE_RETURN) begin
            state_act = send_byte(state, clcd_pkg::CMD_SET_DDRAM, 1'b0, 1'b1, '0, cfg);
          end else if (char_code == clcd_pkg::CH_LINE_FEED) begin
            state_act = send_byte(state, clcd_pkg::CMD_SET_DDRAM | clcd_pkg::CMD_LINE_TWO,
                                  1'b0, 1'b1, '0, cfg);
          end else if (char_code == clcd_pkg::CH_FORM_FEED) begin
            state_act = send_byte(state, clcd_pkg::CMD_CLEAR, 1'b0, 1'b1,
                                  CW'(cfg.clear_wait_ticks), cfg);
          end else begin
            state_act = send_byte(state, char_code, 1'b1, 1'b0, '0, cfg);
          end
          state_act.init_step = clcd_pkg::STEP_DONE;
        end
      end
      default: ;
    endcase
  end

  // Advance at most one expired phase per cycle.
  always_comb begin
    state_base = item_accept ? state_act : state;
    state_next = needs_settle(state_base) ? settle_step(state_base, cfg) : state_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= clcd_pkg::PH_IDLE;
      state.tick_count    <= '0;
      state.init_step     <= '0;
      state.pending_byte  <= '0;
      state.low_half_next <= 1'b0;
      state.is_command    <= 1'b0;
      state.after_wait    <= '0;
      state.pin_rs        <= 1'b0;
      state.pin_e         <= 1'b0;
      state.pin_data      <= '0;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    status.hold                 = needs_settle(state);
    status.done                 = (item_accept || needs_settle(state)) &&
                                  !needs_settle(state_next);
    status.result.reg_select    = state_next.pin_rs;
    status.result.enable_pin    = state_next.pin_e;
    status.result.data_nibble   = state_next.pin_data;
    status.result.busy_res      = (state_next.phase != clcd_pkg::PH_IDLE);
    status.result.dropped       = item_accept && drop_now;
  end

endmodule

### hdl/char_lcd_nibble_interface_unit.sv
// Top level of the character LCD nibble interface: stream ports, output register.
// Depends on clcd_pkg, clcd_cfg_regs and clcd_sequencer.
//
// Drives an HD44780-style character display over a 4-bit bus. Each input transfer is
// one item: a one-microsecond tick, an init request or a put of one byte. The action
// travels in s_tuser and the byte to put in s_tdata. Each item produces exactly one
// output transfer carrying the pin levels after the item: RS in m_tuser, and E, DB7..DB4,
// a busy flag and a dropped flag (an init or put refused because a sequence is still
// running) in m_tdata. Normally the item is registered into the sequencer state and its
// result into the output register in the same cycle, and a new item is taken every cycle
// while the output register drains and no phases are chaining. The sequencer applies at
// most one phase change per clock, so when a phase ends with a count of zero (zero-length
// enable strobe, gap or wait) each further chained phase change holds s_tready low; an init
// with every timing register at zero chains forty-three phase changes and holds s_tready
// low until the last of them. Timing registers are written through cfg_we/cfg_index/
// cfg_wdata; the user must write them only while the block is idle, which the block
// itself does not enforce. Indexes beyond the display flags register are ignored.
module char_lcd_nibble_interface_unit (
  input  logic                             clk,
  input  logic                             rst,
  // Input items.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [1:0]                       s_tuser,   // [1:0] action
  input  logic [7:0]                       s_tdata,   // [7:0] char_code
  // Result items.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic                             m_tuser,   // [0] reg_select
  output logic [7:0]                       m_tdata,   // [0] enable_pin, [4:1] data_nibble,
                                                      // [5] busy_res, [6] dropped
  // Configuration writes.
  input  logic                             cfg_we,
  input  logic [clcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  clcd_pkg::cfg_t        cfg;
  clcd_pkg::seq_status_t status;
  logic                  item_accept;

  clcd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Take a new item unless phases are still chaining or the result slot stays full.
  assign s_tready    = !status.hold && (!m_tvalid || m_tready);
  assign item_accept = s_tvalid && s_tready;

  clcd_sequencer u_sequencer (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_accept (item_accept),
    .action      (s_tuser),
    .char_code   (s_tdata),
    .status      (status)
  );

  // Output register: load a finished result, drop valid once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (status.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      m_tuser <= status.result.reg_select;
      m_tdata <= {1'b0, status.result.dropped, status.result.busy_res,
                  status.result.data_nibble, status.result.enable_pin};
    end
  end

endmodule
